FILE: design/q3kdot_pkg.sv
// Package with the shared types, constants and arithmetic functions of the dot product block.
package q3kdot_pkg;

  // Elements carried by one item and the widths of the packed input fields.
  localparam int LANES = 8;
  localparam int LOW_W = 16;
  localparam int HIGH_W = 8;
  localparam int ACT_W = 64;

  // Depth of the queue between the integer front and the float back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Quiet NaN produced by invalid operations such as infinity times zero.
  localparam logic [31:0] QNAN_DEFAULT = 32'hFFC0_0000;
  localparam logic [31:0] QUIET_BIT = 32'h0040_0000;

  // One sub-block's work handed from the front to the back.
  typedef struct packed {
    logic [15:0] sup;
    logic [31:0] sub;
    logic [21:0] ival;
    logic        has_sub;
    logic        row_end;
  } q3kdot_entry_t;

  // Queue status seen by the front and the top level.
  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q3kdot_qstat_t;

  // Float operation between its wide first half and its rounding half.
  typedef struct packed {
    logic               special;
    logic [31:0]        sbits;
    logic               sign;
    logic signed [11:0] exp;
    logic [49:0]        man;
  } q3kdot_fmid_t;

  // Sum of code times activation over the lanes of one item, modulo 2^16.
  function automatic logic [15:0] lane_sum(logic [LOW_W-1:0] lo, logic [HIGH_W-1:0] hi,
                                           logic [ACT_W-1:0] act);
    logic [15:0]        acc;
    logic [2:0]         code;
    logic signed [7:0]  a;
    logic signed [12:0] p;
    acc = '0;
    for (int k = 0; k < LANES; k++) begin
      code = '0;
      a = '0;
      if (2 * k < LOW_W) code[1:0] = lo[2*k +: 2];
      if (k < HIGH_W) code[2] = hi[k];
      if (8 * k < ACT_W) a = act[8*k +: 8];
      p = $signed({1'b0, code}) * a;
      acc = acc + 16'(p);
    end
    return acc;
  endfunction

  // Normalize and round to nearest even; value is (m / 2^49) * 2^(e - 127).
  function automatic logic [31:0] round_pack(logic s, logic signed [11:0] e, logic [49:0] m);
    logic [5:0]         lz;
    logic               found;
    logic [49:0]        mn;
    logic signed [11:0] en;
    logic [11:0]        sh;
    logic [49:0]        ms;
    logic               extra;
    logic [7:0]         ef;
    logic               inc;
    logic [30:0]        mag;
    lz = '0;
    found = 1'b0;
    extra = 1'b0;
    for (int i = 49; i >= 0; i--) begin
      if (!found && m[i]) begin
        lz = 6'(49 - i);
        found = 1'b1;
      end
    end
    if (m == '0) return {s, 31'b0};
    mn = m << lz;
    en = e - $signed({6'b0, lz});
    if (en >= 255) return {s, 8'hFF, 23'b0};
    if (en >= 1) begin
      ms = mn;
      ef = en[7:0];
    end else begin
      sh = 12'(1 - en);
      ef = '0;
      if (sh >= 12'd50) begin
        ms = '0;
        extra = |mn;
      end else begin
        ms = mn >> sh;
        extra = |(mn & ~({50{1'b1}} << sh));
      end
    end
    inc = ms[25] & ((|ms[24:0]) | extra | ms[26]);
    mag = {ef, ms[48:26]} + 31'(inc);
    return {s, mag};
  endfunction

  // Exact conversion of a half-precision value to single precision.
  function automatic logic [31:0] half_to_bits(logic [15:0] h);
    logic [4:0]         ex;
    logic [9:0]         man;
    logic signed [11:0] e;
    ex = h[14:10];
    man = h[9:0];
    if (ex == 5'h1F) begin
      return {h[15], 8'hFF, man, 13'b0} | ((man != '0) ? QUIET_BIT : 32'b0);
    end
    e = (ex == '0) ? 12'sd113 : $signed(12'(ex) + 12'd112);
    return round_pack(h[15], e, {(ex != '0), man, 39'b0});
  endfunction

  // Exact conversion of a 22-bit signed integer to single precision.
  function automatic logic [31:0] int_to_bits(logic [21:0] v);
    logic [21:0] mag;
    mag = v[21] ? (22'd0 - v) : v;
    return round_pack(v[21], 12'sd148, {mag, 28'b0});
  endfunction

  // Special cases and mantissa product of a single-precision multiply.
  function automatic q3kdot_fmid_t fmul_pre(logic [31:0] a, logic [31:0] b);
    q3kdot_fmid_t r;
    logic         nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
    logic [23:0]  ma, mb;
    logic [7:0]   ea, eb;
    nan_a = (a[30:23] == 8'hFF) && (a[22:0] != '0);
    nan_b = (b[30:23] == 8'hFF) && (b[22:0] != '0);
    inf_a = (a[30:23] == 8'hFF) && (a[22:0] == '0);
    inf_b = (b[30:23] == 8'hFF) && (b[22:0] == '0);
    zero_a = (a[30:0] == '0);
    zero_b = (b[30:0] == '0);
    r = '0;
    r.sign = a[31] ^ b[31];
    r.special = 1'b1;
    if (nan_a) r.sbits = a | QUIET_BIT;
    else if (nan_b) r.sbits = b | QUIET_BIT;
    else if ((inf_a && zero_b) || (zero_a && inf_b)) r.sbits = QNAN_DEFAULT;
    else if (inf_a || inf_b) r.sbits = {r.sign, 8'hFF, 23'b0};
    else if (zero_a || zero_b) r.sbits = {r.sign, 31'b0};
    else begin
      r.special = 1'b0;
      ea = (a[30:23] == '0) ? 8'd1 : a[30:23];
      eb = (b[30:23] == '0) ? 8'd1 : b[30:23];
      ma = {(a[30:23] != '0), a[22:0]};
      mb = {(b[30:23] != '0), b[22:0]};
      r.man = {48'(ma) * 48'(mb), 2'b00};
      r.exp = $signed(12'(ea) + 12'(eb) - 12'd126);
    end
    return r;
  endfunction

  // Special cases and aligned sum of a single-precision add.
  function automatic q3kdot_fmid_t fadd_pre(logic [31:0] a, logic [31:0] b);
    q3kdot_fmid_t r;
    logic         nan_a, nan_b, inf_a, inf_b;
    logic [31:0]  x, y;
    logic [7:0]   ex, ey, d;
    logic [49:0]  xw, yw, ys;
    logic         st;
    nan_a = (a[30:23] == 8'hFF) && (a[22:0] != '0);
    nan_b = (b[30:23] == 8'hFF) && (b[22:0] != '0);
    inf_a = (a[30:23] == 8'hFF) && (a[22:0] == '0);
    inf_b = (b[30:23] == 8'hFF) && (b[22:0] == '0);
    r = '0;
    r.special = 1'b1;
    if (nan_a) r.sbits = a | QUIET_BIT;
    else if (nan_b) r.sbits = b | QUIET_BIT;
    else if (inf_a && inf_b && (a[31] != b[31])) r.sbits = QNAN_DEFAULT;
    else if (inf_a) r.sbits = a;
    else if (inf_b) r.sbits = b;
    else begin
      r.special = 1'b0;
      if (a[30:0] >= b[30:0]) begin
        x = a;
        y = b;
      end else begin
        x = b;
        y = a;
      end
      ex = (x[30:23] == '0) ? 8'd1 : x[30:23];
      ey = (y[30:23] == '0) ? 8'd1 : y[30:23];
      d = ex - ey;
      xw = {1'b0, (x[30:23] != '0), x[22:0], 25'b0};
      yw = {1'b0, (y[30:23] != '0), y[22:0], 25'b0};
      if (d >= 8'd50) begin
        ys = '0;
        st = |yw;
      end else begin
        ys = yw >> d;
        st = |(yw & ~({50{1'b1}} << d));
      end
      ys[0] = ys[0] | st;
      r.man = (x[31] == y[31]) ? (xw + ys) : (xw - ys);
      r.sign = (r.man == '0) ? (x[31] & y[31]) : x[31];
      r.exp = $signed(12'(ex) + 12'd1);
    end
    return r;
  endfunction

  // Second half of a float operation: pass a special result or round.
  function automatic logic [31:0] fp_post(q3kdot_fmid_t m);
    return m.special ? m.sbits : round_pack(m.sign, m.exp, m.man);
  endfunction

endpackage

FILE: design/q3kdot_if.sv
// Handshake channels for the input items and the result items.
interface q3kdot_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] weight_low_bits;
  logic [7:0]  weight_high_bits;
  logic [63:0] activations;
  logic [5:0]  group_scale_code;
  logic [11:0] group_act_sum;
  logic [31:0] sub_scale_bits;
  logic [15:0] super_scale_bits;
  logic        group_end;
  logic        subblock_end;
  logic        row_end;

  modport source(output valid, weight_low_bits, weight_high_bits, activations,
                 group_scale_code, group_act_sum, sub_scale_bits, super_scale_bits,
                 group_end, subblock_end, row_end, input ready);
  modport sink(input valid, weight_low_bits, weight_high_bits, activations,
               group_scale_code, group_act_sum, sub_scale_bits, super_scale_bits,
               group_end, subblock_end, row_end, output ready);
endinterface

interface q3kdot_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] dot_value_bits;

  modport source(output valid, dot_value_bits, input ready);
  modport sink(input valid, dot_value_bits, output ready);
endinterface

FILE: design/q3kdot_fifo.sv
// Two-entry queue between the integer front and the float back.
module q3kdot_fifo import q3kdot_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  q3kdot_entry_t push_data_i,
  input  logic          pop_i,
  output q3kdot_entry_t pop_data_o,
  output q3kdot_qstat_t stat_o
);

  q3kdot_entry_t mem_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] count_q;

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= push_data_i;
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      count_q <= '0;
    end else begin
      if (push_i) wptr_q <= (32'(wptr_q) == QDEPTH - 1) ? '0 : wptr_q + 1'b1;
      if (pop_i) rptr_q <= (32'(rptr_q) == QDEPTH - 1) ? '0 : rptr_q + 1'b1;
      count_q <= count_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
    end
  end

  assign pop_data_o = mem_q[rptr_q];
  assign stat_o.full = (32'(count_q) == QDEPTH);
  assign stat_o.empty = (count_q == '0);
  assign stat_o.count = count_q;

endmodule

FILE: design/q3kdot_front.sv
// Integer front: lane products, group terms and sub-block integers.
module q3kdot_front import q3kdot_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  q3kdot_in_if.sink     in_i,
  input  q3kdot_qstat_t qstat_i,
  output logic          push_o,
  output q3kdot_entry_t entry_o
);

  typedef struct packed {
    logic [15:0] lsum;
    logic [5:0]  scode;
    logic [11:0] asum;
    logic [31:0] sub;
    logic [15:0] sup;
    logic        ge;
    logic        se;
    logic        re;
  } q3kdot_s1_t;

  q3kdot_s1_t         s1_q;
  logic               s1_valid_q;
  logic [15:0]        gp_q, gp_d, gp_new;
  logic [21:0]        int_q, int_d, int_grp;
  logic signed [6:0]  sc_m;
  logic signed [16:0] diff;
  logic signed [23:0] term;
  logic               needs_push, adv;

  // The held item moves on unless it needs a queue slot that is not there.
  assign needs_push = s1_q.se | s1_q.re;
  assign adv = s1_valid_q && !(needs_push && qstat_i.full);
  assign in_i.ready = !s1_valid_q || adv;

  // Lane products are summed as the item is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_q.lsum <= lane_sum(in_i.weight_low_bits, in_i.weight_high_bits, in_i.activations);
      s1_q.scode <= in_i.group_scale_code;
      s1_q.asum <= in_i.group_act_sum;
      s1_q.sub <= in_i.sub_scale_bits;
      s1_q.sup <= in_i.super_scale_bits;
      s1_q.ge <= in_i.group_end;
      s1_q.se <= in_i.subblock_end;
      s1_q.re <= in_i.row_end;
    end
  end

  // Group term: (scale code - 32) * (partial - 4 * activation sum).
  always_comb begin
    gp_new = gp_q + s1_q.lsum;
    sc_m = $signed({1'b0, s1_q.scode}) - 7'sd32;
    diff = 17'(signed'(gp_new)) - 17'(signed'({s1_q.asum, 2'b00}));
    term = 24'(sc_m) * 24'(diff);
    int_grp = s1_q.ge ? (int_q + term[21:0]) : int_q;
    gp_d = s1_q.ge ? '0 : gp_new;
    int_d = s1_q.se ? '0 : int_grp;
    if (s1_q.re) begin
      gp_d = '0;
      int_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gp_q <= '0;
      int_q <= '0;
    end else if (adv) begin
      gp_q <= gp_d;
      int_q <= int_d;
    end
  end

  // Sub-block ends and row ends go to the back.
  assign push_o = adv && needs_push;
  assign entry_o.sup = s1_q.sup;
  assign entry_o.sub = s1_q.sub;
  assign entry_o.ival = int_grp;
  assign entry_o.has_sub = s1_q.se;
  assign entry_o.row_end = s1_q.re;

endmodule

FILE: design/q3kdot_back.sv
// Float back: scale product, contribution and row accumulation, one operation at a time.
module q3kdot_back import q3kdot_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  q3kdot_qstat_t qstat_i,
  input  q3kdot_entry_t entry_i,
  output logic          pop_o,
  q3kdot_out_if.source  out_o
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_CVT  = 9'b000000010,
    S_M1A  = 9'b000000100,
    S_M1B  = 9'b000001000,
    S_M2A  = 9'b000010000,
    S_M2B  = 9'b000100000,
    S_AA   = 9'b001000000,
    S_AB   = 9'b010000000,
    S_FIN  = 9'b100000000
  } q3kdot_state_e;

  q3kdot_state_e state_q, state_d;
  q3kdot_entry_t ent_q;
  q3kdot_fmid_t  mid_q, mul_mid, add_mid;
  logic [31:0]   half_q, ival_q, prod_q, acc_q, out_q;
  logic [31:0]   mul_a, mul_b, post_bits;
  logic          out_valid_q, out_free;

  assign out_free = !out_valid_q || out_o.ready;
  assign pop_o = (state_q == S_IDLE) && !qstat_i.empty;

  // One multiplier serves both products; one rounding stage serves them and the add.
  assign mul_a = (state_q == S_M1A) ? half_q : prod_q;
  assign mul_b = (state_q == S_M1A) ? ent_q.sub : ival_q;
  assign mul_mid = fmul_pre(mul_a, mul_b);
  assign add_mid = fadd_pre(acc_q, prod_q);
  assign post_bits = fp_post(mid_q);

  // Sequencer over the float steps of one entry.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (!qstat_i.empty) state_d = entry_i.has_sub ? S_CVT : S_FIN;
      S_CVT:  state_d = S_M1A;
      S_M1A:  state_d = S_M1B;
      S_M1B:  state_d = S_M2A;
      S_M2A:  state_d = S_M2B;
      S_M2B:  state_d = S_AA;
      S_AA:   state_d = S_AB;
      S_AB:   state_d = S_FIN;
      S_FIN:  if (!ent_q.row_end || out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control state, the accumulator and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      acc_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_AB) acc_q <= post_bits;
      if (out_o.ready) out_valid_q <= 1'b0;
      if (state_q == S_FIN && ent_q.row_end && out_free) begin
        out_valid_q <= 1'b1;
        acc_q <= '0;
      end
    end
  end

  // Operands and intermediate results.
  always_ff @(posedge clk_i) begin
    if (pop_o) ent_q <= entry_i;
    if (state_q == S_CVT) begin
      half_q <= half_to_bits(ent_q.sup);
      ival_q <= int_to_bits(ent_q.ival);
    end
    if (state_q == S_M1A || state_q == S_M2A) mid_q <= mul_mid;
    if (state_q == S_AA) mid_q <= add_mid;
    if (state_q == S_M1B || state_q == S_M2B) prod_q <= post_bits;
    if (state_q == S_FIN && ent_q.row_end && out_free) out_q <= acc_q;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.dot_value_bits = out_q;

endmodule

FILE: design/q3k_q8k_block_dot_product.sv
// Top level of the 3-bit weight by 8-bit activation row dot product.
// The integer front takes one item per cycle unless the queue is full and the
// held item must push, and keeps the group partial and sub-block integer exact
// in two's complement. Each item that ends a sub-block or a row becomes one
// entry in a two-entry queue to the float back, which rounds every operation
// to single precision, nearest even, subnormals kept. For an entry with a
// sub-block the back steps through pop, conversion, two multiplies and one
// add, each in two steps through one shared rounding stage, then finish; a
// row end alone goes from pop to finish. The float back sets the sustained
// rate, and the front keeps taking items while the queue has room. The
// result leaves through an output register, so the back keeps working while
// a finished row waits to be taken, until the next row end reaches finish.
module q3k_q8k_block_dot_product import q3kdot_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  q3kdot_in_if.sink    in_i,
  q3kdot_out_if.source out_o
);

  q3kdot_entry_t q_push_data, q_pop_data;
  q3kdot_qstat_t qstat;
  logic          q_push, q_pop;

  q3kdot_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .qstat_i (qstat),
    .push_o  (q_push),
    .entry_o (q_push_data)
  );

  q3kdot_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .pop_i       (q_pop),
    .pop_data_o  (q_pop_data),
    .stat_o      (qstat)
  );

  q3kdot_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .qstat_i (qstat),
    .entry_i (q_pop_data),
    .pop_o   (q_pop),
    .out_o   (out_o)
  );

  // The front never writes a full queue and the back never reads an empty one.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && qstat.full)) else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_pop && qstat.empty)) else $error("queue read while empty");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(qstat.count) <= QDEPTH) else $error("queue count beyond depth");

endmodule
